/* src/vfm_pkg.sv */
`timescale 1ns / 1ps

package vfm_pkg;

  localparam int unsigned NUM_FACES  = 6;
  localparam int unsigned NUM_VERTS  = 4;
  localparam int unsigned CENTRE_BIT = 13;
  localparam logic [7:0]  MATERIAL_ID = 8'd1;

  typedef struct packed {
    logic [5:0]  pos_x;
    logic [5:0]  pos_y;
    logic [5:0]  pos_z;
    logic [26:0] neighbour_solid;
  } vfm_in_t;

  typedef struct packed {
    logic [31:0] vertex_word;
    logic        last_vertex;
  } vfm_out_t;

  typedef struct packed {
    logic [5:0]                 pos_x;
    logic [5:0]                 pos_y;
    logic [5:0]                 pos_z;
    logic [5:0]                 faces;
    logic [5:0][3:0][1:0]       occ;
  } vfm_job_t;

  // face neighbour bit, order +x -x +y -y +z -z
  localparam logic [4:0] FACE_BIT [NUM_FACES] = '{5'd22, 5'd4, 5'd16, 5'd10, 5'd14, 5'd12};

  // corner offset {x, y, z} per face and vertex
  localparam logic [2:0] CORNER_OFF [NUM_FACES][NUM_VERTS] = '{
    '{3'b100, 3'b110, 3'b101, 3'b111},
    '{3'b000, 3'b001, 3'b010, 3'b011},
    '{3'b010, 3'b011, 3'b110, 3'b111},
    '{3'b000, 3'b100, 3'b001, 3'b101},
    '{3'b001, 3'b101, 3'b011, 3'b111},
    '{3'b000, 3'b010, 3'b100, 3'b110}
  };

  // side a, diagonal, side b
  localparam logic [4:0] OCC_TAPS [NUM_FACES][NUM_VERTS][3] = '{
    '{'{5'd21, 5'd18, 5'd19}, '{5'd21, 5'd24, 5'd25},
      '{5'd23, 5'd20, 5'd19}, '{5'd23, 5'd26, 5'd25}},
    '{'{5'd3,  5'd0,  5'd1},  '{5'd5,  5'd2,  5'd1},
      '{5'd3,  5'd6,  5'd7},  '{5'd5,  5'd8,  5'd7}},
    '{'{5'd15, 5'd6,  5'd7},  '{5'd17, 5'd8,  5'd7},
      '{5'd15, 5'd24, 5'd25}, '{5'd17, 5'd26, 5'd25}},
    '{'{5'd9,  5'd0,  5'd1},  '{5'd9,  5'd18, 5'd19},
      '{5'd11, 5'd2,  5'd1},  '{5'd11, 5'd20, 5'd19}},
    '{'{5'd11, 5'd2,  5'd5},  '{5'd11, 5'd20, 5'd23},
      '{5'd17, 5'd8,  5'd5},  '{5'd17, 5'd26, 5'd23}},
    '{'{5'd9,  5'd0,  5'd3},  '{5'd15, 5'd6,  5'd3},
      '{5'd9,  5'd18, 5'd21}, '{5'd15, 5'd24, 5'd21}}
  };

  function automatic logic [1:0] occ_level(input logic a, input logic c, input logic b);
    logic [1:0] lvl;
    if (a && b) begin
      lvl = 2'd0;
    end else begin
      lvl = 2'd3 - {1'b0, a} - {1'b0, b} - {1'b0, c};
    end
    return lvl;
  endfunction

endpackage

/* src/voxel_face_mesher_with_ao.sv */
`timescale 1ns / 1ps
// Path: the first vertex of an item passes the job queue, the emit sequencer and the
//   result register when the emit sequencer is idle and the job queue is empty.
// Rate: one vertex word per cycle from the emit sequencer while results are popped; an
//   item with n exposed faces gives 4*n words (at most 24); items with none take no emit time.
// Input is taken every cycle while the QUEUE_DEPTH-entry job queue has room.
// Reset (rst, synchronous) empties queue and output, sets occlusion_enable to 1.
module voxel_face_mesher_with_ao #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  vfm_pkg::vfm_in_t  item,
  output logic              empty,
  input  logic              pop,
  output vfm_pkg::vfm_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import vfm_pkg::*;

  logic     occlusion_enable;
  logic     job_push;
  vfm_job_t job_in;
  vfm_job_t job_out;
  logic     job_valid;
  logic     job_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      occlusion_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      occlusion_enable <= cfg_data;
    end
  end

  vfm_front u_front (
    .item     (item),
    .accept   (push && !full),
    .occ_en   (occlusion_enable),
    .job_push (job_push),
    .job      (job_in)
  );

  vfm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_data  (job_in),
    .rd_en    (job_take),
    .rd_data  (job_out),
    .rd_valid (job_valid),
    .full     (full)
  );

  vfm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_valid (job_valid),
    .job_take  (job_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* src/vfm_front.sv */
`timescale 1ns / 1ps

module vfm_front (
  input  vfm_pkg::vfm_in_t  item,
  input  logic              accept,
  input  logic              occ_en,
  output logic              job_push,
  output vfm_pkg::vfm_job_t job
);
  import vfm_pkg::*;

  logic [26:0] mask;

  assign mask = item.neighbour_solid;

  always_comb begin
    job.pos_x = item.pos_x;
    job.pos_y = item.pos_y;
    job.pos_z = item.pos_z;
    for (int f = 0; f < NUM_FACES; f++) begin
      job.faces[f] = ~mask[FACE_BIT[f]];
      for (int v = 0; v < NUM_VERTS; v++) begin
        job.occ[f][v] = occ_en ? occ_level(mask[OCC_TAPS[f][v][0]],
                                           mask[OCC_TAPS[f][v][1]],
                                           mask[OCC_TAPS[f][v][2]]) : 2'd0;
      end
    end
  end

  // drop empty centres and fully enclosed voxels
  assign job_push = accept && mask[CENTRE_BIT] && (|job.faces);

endmodule

/* src/vfm_queue.sv */
`timescale 1ns / 1ps

module vfm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  vfm_pkg::vfm_job_t wr_data,
  input  logic              rd_en,
  output vfm_pkg::vfm_job_t rd_data,
  output logic              rd_valid,
  output logic              full
);
  import vfm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  vfm_job_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/vfm_back.sv */
`timescale 1ns / 1ps

module vfm_back (
  input  logic              clk,
  input  logic              rst,
  input  vfm_pkg::vfm_job_t job,
  input  logic              job_valid,
  output logic              job_take,
  output logic              empty,
  input  logic              pop,
  output vfm_pkg::vfm_out_t result
);
  import vfm_pkg::*;

  vfm_job_t   cur;
  logic       busy;
  logic [5:0] remaining;
  logic [1:0] vtx;
  logic       ovalid;

  logic [2:0]  face;
  logic [5:0]  remaining_next;
  logic        last;
  logic        advance;
  logic [2:0]  off;
  logic [6:0]  cx;
  logic [6:0]  cy;
  logic [6:0]  cz;
  logic [31:0] word;

  always_comb begin
    face = 3'd0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (remaining[f]) begin
        face = 3'(f);
      end
    end
  end

  always_comb begin
    remaining_next       = remaining;
    remaining_next[face] = 1'b0;
  end

  assign last    = (vtx == 2'd3) && (remaining_next == '0);
  assign advance = busy && (!ovalid || pop);
  assign job_take = job_valid && (!busy || (advance && last));
  assign empty   = !ovalid;

  assign off  = CORNER_OFF[face][vtx];
  assign cx   = {1'b0, cur.pos_x} + 7'(off[2]);
  assign cy   = {1'b0, cur.pos_y} + 7'(off[1]);
  assign cz   = {1'b0, cur.pos_z} + 7'(off[0]);
  assign word = {cur.occ[face][vtx], 1'b0, MATERIAL_ID, cz, cy, cx};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
      vtx    <= 2'd0;
    end else begin
      if (advance) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
      if (job_take) begin
        busy <= 1'b1;
        vtx  <= 2'd0;
      end else if (advance) begin
        vtx <= vtx + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.vertex_word <= word;
      result.last_vertex <= last;
    end
    if (job_take) begin
      cur       <= job;
      remaining <= job.faces;
    end else if (advance && vtx == 2'd3) begin
      remaining <= remaining_next;
    end
  end

endmodule

/* src/vfm_checker.sv */
`timescale 1ns / 1ps

module vfm_assertions (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input vfm_pkg::vfm_out_t result
);
  import vfm_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not empty after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_quad_continues: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !result.last_vertex |=> !empty)
    else $error("vertex stream broke inside an item");

  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    !(push && !full) |=> !$rose(full))
    else $error("full rose without a request");

endmodule

bind voxel_face_mesher_with_ao vfm_assertions u_checker (.*);
